@@ design/kctc_pkg.sv @@
// ---------------------------------------------------------------------------
// kctc_pkg: shared types and constants for the key-event translator
// Key codes, layout ROMs, the command record and the command-queue sizing.
// ---------------------------------------------------------------------------
package kctc_pkg;

	// Number of terminals reachable with alt + digit (1 .. 4)
	localparam int unsigned TERMINAL_COUNT = 4;

	// Command queue between front and back (power of two)
	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	// Event class and key values
	localparam logic [15:0] EV_KEY      = 16'd1;
	localparam logic [1:0]  KV_RELEASE  = 2'd0;

	// Key codes
	localparam logic [9:0] KEY_LSHIFT   = 10'd42;
	localparam logic [9:0] KEY_RSHIFT   = 10'd54;
	localparam logic [9:0] KEY_LALT     = 10'd56;
	localparam logic [9:0] KEY_RALT     = 10'd100;
	localparam logic [9:0] KEY_LCTRL    = 10'd29;
	localparam logic [9:0] KEY_RCTRL    = 10'd97;
	localparam logic [9:0] KEY_ROM_LAST = 10'd53;
	localparam logic [9:0] KEY_SPACE    = 10'd57;
	localparam logic [9:0] KEY_UP       = 10'd103;
	localparam logic [9:0] KEY_LEFT     = 10'd105;
	localparam logic [9:0] KEY_RIGHT    = 10'd106;
	localparam logic [9:0] KEY_DOWN     = 10'd108;
	localparam logic [9:0] KEY_DELETE   = 10'd111;
	localparam logic [9:0] KEY_DIGIT1   = 10'd2;

	// Character bytes
	localparam logic [7:0] CH_ESC       = 8'h1B;
	localparam logic [7:0] CH_BRACKET   = 8'h5B;
	localparam logic [7:0] CH_BS        = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;
	localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
	localparam logic [7:0] CH_CTRL_OFS  = 8'h60;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_B   = 8'h42;
	localparam logic [7:0] CH_UPPER_C   = 8'h43;
	localparam logic [7:0] CH_UPPER_D   = 8'h44;

	// Result kinds
	localparam logic OUT_CHAR   = 1'b0;
	localparam logic OUT_SELECT = 1'b1;

	localparam int unsigned ROM_DEPTH = 54;

	localparam logic [7:0] ROM_PLAIN [ROM_DEPTH] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0D, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
		8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
		8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
		8'h2E, 8'h2F
	};

	localparam logic [7:0] ROM_SHIFT [ROM_DEPTH] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0D, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
		8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
		8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
		8'h3E, 8'h3F
	};

	// Classified request handed from front to back
	typedef enum logic [1:0] {
		CMD_CHAR   = 2'd0,  // one character byte
		CMD_SELECT = 2'd1,  // one terminal select
		CMD_ESC    = 2'd2   // ESC '[' letter, optionally backspace
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] ch;     // byte for CMD_CHAR, final letter for CMD_ESC
		logic [3:0] tty;    // terminal for CMD_SELECT
		logic       del;    // CMD_ESC: append backspace
	} cmd_t;

endpackage

@@ design/kctc_front.sv @@
// ---------------------------------------------------------------------------
// kctc_front: event acceptance and classification
// Tracks the modifier flags and turns each key event into at most one
// command for the back end; events that give nothing are dropped here.
// ---------------------------------------------------------------------------
module kctc_front import kctc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        q_full,
	input  logic [15:0] event_type,
	input  logic [9:0]  key_code,
	input  logic [1:0]  key_value,
	output logic        cmd_push,
	output cmd_t        cmd
);

	logic       shift_q;
	logic       alt_q;
	logic       ctrl_q;
	logic       accept;
	logic       is_key;
	logic       is_shift;
	logic       is_alt;
	logic       is_ctrl;
	logic       pressed;
	logic [7:0] rom_ch;
	logic [7:0] fold_ch;
	logic       want;

	assign accept   = push && !q_full;
	assign is_key   = (event_type == EV_KEY);
	assign is_shift = (key_code == KEY_LSHIFT) || (key_code == KEY_RSHIFT);
	assign is_alt   = (key_code == KEY_LALT)   || (key_code == KEY_RALT);
	assign is_ctrl  = (key_code == KEY_LCTRL)  || (key_code == KEY_RCTRL);
	assign pressed  = (key_value != KV_RELEASE);

	// Look up the layout and fold control letters
	always_comb begin
		rom_ch = shift_q ? ROM_SHIFT[key_code[5:0]] : ROM_PLAIN[key_code[5:0]];
		if (ctrl_q && rom_ch >= CH_LOWER_A && rom_ch <= CH_LOWER_Z) begin
			fold_ch = rom_ch - CH_CTRL_OFS;
		end else begin
			fold_ch = rom_ch;
		end
	end

	// Classify the event into a command
	always_comb begin
		want     = 1'b0;
		cmd.kind = CMD_CHAR;
		cmd.ch   = fold_ch;
		cmd.tty  = 4'(key_code - KEY_DIGIT1);
		cmd.del  = 1'b0;
		if (is_key && !is_shift && !is_alt && !is_ctrl) begin
			if (alt_q) begin
				cmd.kind = CMD_SELECT;
				want = (key_code >= KEY_DIGIT1) &&
					(key_code < KEY_DIGIT1 + 10'(TERMINAL_COUNT));
			end else if (pressed) begin
				if (key_code <= KEY_ROM_LAST) begin
					want = (fold_ch != 8'h00);
				end else if (key_code == KEY_SPACE) begin
					cmd.ch = CH_SPACE;
					want   = 1'b1;
				end else if (key_code == KEY_UP) begin
					cmd.kind = CMD_ESC;
					cmd.ch   = CH_UPPER_A;
					want     = 1'b1;
				end else if (key_code == KEY_DOWN) begin
					cmd.kind = CMD_ESC;
					cmd.ch   = CH_UPPER_B;
					want     = 1'b1;
				end else if (key_code == KEY_LEFT) begin
					cmd.kind = CMD_ESC;
					cmd.ch   = CH_UPPER_D;
					want     = 1'b1;
				end else if (key_code == KEY_RIGHT || key_code == KEY_DELETE) begin
					cmd.kind = CMD_ESC;
					cmd.ch   = CH_UPPER_C;
					cmd.del  = (key_code == KEY_DELETE);
					want     = 1'b1;
				end
			end
		end
	end

	assign cmd_push = accept && want;

	// Hold the modifier flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
			alt_q   <= 1'b0;
			ctrl_q  <= 1'b0;
		end else if (accept && is_key) begin
			if (is_shift) shift_q <= pressed;
			if (is_alt)   alt_q   <= pressed;
			if (is_ctrl)  ctrl_q  <= pressed;
		end
	end

endmodule

@@ design/kctc_cmdq.sv @@
// ---------------------------------------------------------------------------
// kctc_cmdq: command queue between front and back
// Small register queue; the head is shown while the queue is not empty.
// ---------------------------------------------------------------------------
module kctc_cmdq import kctc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wr_cmd,
	input  logic rd,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t               mem_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_CW-1:0] count_q;

	assign full  = (count_q == CMDQ_CW'(CMDQ_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Store a request
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/kctc_back.sv @@
// ---------------------------------------------------------------------------
// kctc_back: result sequencer
// Expands the head command into one to four results, one per cycle unless
// stalled, into an output register that is popped by the receiver.
// ---------------------------------------------------------------------------
module kctc_back import kctc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cmd_t       head,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic       out_kind,
	output logic [7:0] out_char,
	output logic [3:0] tty_index,
	output logic       last
);

	logic [1:0] step_q;
	logic       valid_q;
	logic       out_kind_q;
	logic [7:0] out_char_q;
	logic [3:0] tty_q;
	logic       last_q;
	logic       load;
	logic       nx_kind;
	logic [7:0] nx_char;
	logic [3:0] nx_tty;
	logic       nx_last;

	// Form the result for the current step of the head command
	always_comb begin
		nx_kind = OUT_CHAR;
		nx_char = head.ch;
		nx_tty  = 4'd0;
		nx_last = 1'b1;
		case (head.kind)
			CMD_SELECT: begin
				nx_kind = OUT_SELECT;
				nx_char = 8'h00;
				nx_tty  = head.tty;
			end
			CMD_ESC: begin
				case (step_q)
					2'd0: begin
						nx_char = CH_ESC;
						nx_last = 1'b0;
					end
					2'd1: begin
						nx_char = CH_BRACKET;
						nx_last = 1'b0;
					end
					2'd2: begin
						nx_char = head.ch;
						nx_last = !head.del;
					end
					default: begin
						nx_char = CH_BS;
					end
				endcase
			end
			default: begin
				nx_char = head.ch;
			end
		endcase
	end

	assign load = !q_empty && (!valid_q || pop);
	assign q_rd = load && nx_last;

	// Advance the step counter and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			step_q  <= nx_last ? 2'd0 : step_q + 2'd1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= nx_kind;
			out_char_q <= nx_char;
			tty_q      <= nx_tty;
			last_q     <= nx_last;
		end
	end

	assign empty     = !valid_q;
	assign out_kind  = out_kind_q;
	assign out_char  = out_char_q;
	assign tty_index = tty_q;
	assign last      = last_q;

endmodule

@@ design/keycode_to_terminal_chars_top.sv @@
// ---------------------------------------------------------------------------
// keycode_to_terminal_chars_top: key events to terminal characters
// Usage: write key events with push while full is low; each is taken at
// the edge where push is high and full is low. Results are read like a
// queue: while empty is low the oldest result sits on out_kind, out_char,
// tty_index and last, and pop high at an edge takes it. last marks the
// final result of one event.
// The first result of an event goes through the command queue and then the
// output register. Events that give no result (modifiers, releases without
// alt, swallowed keys, other event classes) are absorbed at once.
// Throughput: one event per cycle unless full, into a four-entry command
// queue; the result sequencer emits one result per cycle unless stalled by
// pop, and an event gives one to four results (arrows three, delete four).
// Stall: when pop stays low the output register holds, the queue fills
// and full rises; events are never lost.
// Reset: arst_n clears the modifier flags, the queue and the output.
// ---------------------------------------------------------------------------
module keycode_to_terminal_chars_top import kctc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] event_type,
	input  logic [9:0]  key_code,
	input  logic [1:0]  key_value,
	output logic        empty,
	input  logic        pop,
	output logic        out_kind,
	output logic [7:0]  out_char,
	output logic [3:0]  tty_index,
	output logic        last
);

	logic q_full;
	logic q_empty;
	logic q_rd;
	logic cmd_push;
	cmd_t cmd;
	cmd_t head;

	assign full = q_full;

	// Classify incoming events
	kctc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (q_full),
		.event_type (event_type),
		.key_code   (key_code),
		.key_value  (key_value),
		.cmd_push   (cmd_push),
		.cmd        (cmd)
	);

	// Decouple front and back
	kctc_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wr_cmd (cmd),
		.rd     (q_rd),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	// Expand requests into results
	kctc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.out_kind  (out_kind),
		.out_char  (out_char),
		.tty_index (tty_index),
		.last      (last)
	);

	// A request is retired only from a non-empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_rd |-> !q_empty)
		else $error("request retired from empty queue");

	// A terminal select is a single, final result with no character
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == OUT_SELECT) |-> (last && out_char == 8'h00))
		else $error("malformed terminal select result");

	// A selected terminal is within range
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_kind == OUT_SELECT) |-> (tty_index < 4'(TERMINAL_COUNT)))
		else $error("terminal index out of range");

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the key-event to terminal-character block
// Key events go in through a queue-style driver and results come out through
// a queue-style monitor. Each accepted event is translated by a local
// predictor that has its own modifier flags and layout tables, and each
// result is compared with the oldest predicted one. Both sides idle at
// random. The receiver holds off once so that the block stalls its input,
// and the sender drains the block twice before it goes on.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kctc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned RANDOM_KEYS  = 115;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned MAX_REPORTS  = 10;

	localparam logic [1:0] KV_PRESS  = 2'd1;
	localparam logic [1:0] KV_REPEAT = 2'd2;

	// Key codes used by name in the directed part
	localparam logic [9:0] KEY_NONE   = 10'd0;
	localparam logic [9:0] KEY_ESCAPE = 10'd1;
	localparam logic [9:0] KEY_DIGIT2 = 10'd3;
	localparam logic [9:0] KEY_DIGIT4 = 10'd5;
	localparam logic [9:0] KEY_A      = 10'd30;
	localparam logic [9:0] KEY_Z      = 10'd44;
	localparam logic [9:0] KEY_TOP    = 10'd767;

	localparam logic [9:0] MODIFIER_KEYS [6] = '{KEY_LSHIFT, KEY_RSHIFT, KEY_LALT,
		KEY_RALT, KEY_LCTRL, KEY_RCTRL};
	localparam logic [9:0] CURSOR_KEYS [5] = '{KEY_UP, KEY_DOWN, KEY_LEFT,
		KEY_RIGHT, KEY_DELETE};

	// US layout, unshifted and shifted, key codes 0 .. 53
	localparam logic [7:0] LAYOUT_PLAIN [54] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
		8'h5B, 8'h5D, 8'h0D, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C,
		8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
		8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F
	};
	localparam logic [7:0] LAYOUT_SHIFT [54] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
		8'h7B, 8'h7D, 8'h0D, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C,
		8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
		8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F
	};

	typedef struct {
		logic [15:0] ev;
		logic [9:0]  code;
		logic [1:0]  val;
		bit          pause;  // wait for every due result before offering
	} key_event_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
		logic [3:0] tty;
		logic       last;
	} term_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [15:0] event_type = '0;
	logic [9:0]  key_code = '0;
	logic [1:0]  key_value = '0;
	logic        pop = 1'b0;
	logic        full, empty, out_kind, last;
	logic [7:0]  out_char;
	logic [3:0]  tty_index;

	key_event_t  pending_events [$];
	term_out_t   chars_due [$];

	// Predictor modifier flags, clear after reset
	bit shift_on = 1'b0;
	bit alt_on   = 1'b0;
	bit ctrl_on  = 1'b0;

	int unsigned cycle_count = 0;
	int unsigned events_taken = 0;
	int unsigned results_seen = 0;
	int unsigned selects_due = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	logic        rx_hold = 1'b0;
	logic        calm;

	keycode_to_terminal_chars_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.event_type (event_type),
		.key_code   (key_code),
		.key_value  (key_value),
		.empty      (empty),
		.pop        (pop),
		.out_kind   (out_kind),
		.out_char   (out_char),
		.tty_index  (tty_index),
		.last       (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Idle-free stretches on both sides
	assign calm = (cycle_count % 500) < 100;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void queue_event(logic [15:0] ev, logic [9:0] code,
			logic [1:0] val, bit pause = 1'b0);
		key_event_t e;
		e.ev = ev;
		e.code = code;
		e.val = val;
		e.pause = pause;
		pending_events.push_back(e);
	endfunction

	function automatic void due_char(logic [7:0] ch, logic fin);
		chars_due.push_back('{kind: OUT_CHAR, ch: ch, tty: 4'd0, last: fin});
	endfunction

	// Translate one accepted event and append the results it causes
	function automatic void translate_event(logic [15:0] ev, logic [9:0] code,
			logic [1:0] val);
		logic [7:0] c;
		if (ev != EV_KEY)
			return;
		if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
			shift_on = (val != KV_RELEASE);
			return;
		end
		if (code == KEY_LALT || code == KEY_RALT) begin
			alt_on = (val != KV_RELEASE);
			return;
		end
		if (code == KEY_LCTRL || code == KEY_RCTRL) begin
			ctrl_on = (val != KV_RELEASE);
			return;
		end
		// With alt held only the terminal digits count, releases too
		if (alt_on) begin
			if (code >= KEY_DIGIT1 && code < KEY_DIGIT1 + TERMINAL_COUNT) begin
				chars_due.push_back('{kind: OUT_SELECT, ch: 8'd0,
					tty: 4'(code - KEY_DIGIT1), last: 1'b1});
				selects_due++;
			end
			return;
		end
		if (val == KV_RELEASE)
			return;
		if (code <= KEY_ROM_LAST) begin
			c = shift_on ? LAYOUT_SHIFT[code] : LAYOUT_PLAIN[code];
			if (ctrl_on && c >= CH_LOWER_A && c <= CH_LOWER_Z)
				c = c - CH_CTRL_OFS;
			if (c != 8'd0)
				due_char(c, 1'b1);
		end else if (code == KEY_SPACE) begin
			due_char(CH_SPACE, 1'b1);
		end else if (code == KEY_UP || code == KEY_DOWN || code == KEY_LEFT ||
				code == KEY_RIGHT || code == KEY_DELETE) begin
			due_char(CH_ESC, 1'b0);
			due_char(CH_BRACKET, 1'b0);
			case (code)
				KEY_UP:    due_char(CH_UPPER_A, 1'b1);
				KEY_DOWN:  due_char(CH_UPPER_B, 1'b1);
				KEY_LEFT:  due_char(CH_UPPER_D, 1'b1);
				KEY_RIGHT: due_char(CH_UPPER_C, 1'b1);
				default: begin
					due_char(CH_UPPER_C, 1'b0);
					due_char(CH_BS, 1'b1);
				end
			endcase
		end
	endfunction

	// Driver: predict on each accepted request, then offer the next one
	always @(posedge clk) begin
		logic push_n;
		if (arst_n) begin
			if (push && full)
				stall_cycles++;
			if (push && !full) begin
				translate_event(event_type, key_code, key_value);
				events_taken++;
				void'(pending_events.pop_front());
				tx_gap = pick_gap();
			end
			if (!(push && full)) begin
				push_n = 1'b0;
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (pending_events.size() > 0 &&
						!(pending_events[0].pause && chars_due.size() > 0)) begin
					push_n = 1'b1;
					event_type <= pending_events[0].ev;
					key_code   <= pending_events[0].code;
					key_value  <= pending_events[0].val;
				end
				push <= push_n;
			end
		end
	end

	// Monitor: compare each accepted result with the oldest one due
	always @(posedge clk) begin
		term_out_t seen, due;
		if (arst_n) begin
			if (pop && !empty) begin
				seen = '{kind: out_kind, ch: out_char, tty: tty_index, last: last};
				results_seen++;
				if (chars_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: kind=%0d char=%02h tty=%0d last=%0d",
							seen.kind, seen.ch, seen.tty, seen.last);
				end else begin
					due = chars_due.pop_front();
					if (seen.kind !== due.kind || seen.ch !== due.ch ||
							seen.tty !== due.tty || seen.last !== due.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: expected kind=%0d char=%02h tty=%0d last=%0d, got kind=%0d char=%02h tty=%0d last=%0d",
								results_seen, due.kind, due.ch, due.tty, due.last,
								seen.kind, seen.ch, seen.tty, seen.last);
					end
				end
				rx_gap = pick_gap();
			end
			if (rx_hold) begin
				pop <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Hold the receiver off for a long stretch early in the random part
	initial begin
		while (events_taken < 56)
			@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count,
				chars_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned keys_made, r;
		logic [9:0]  code;
		bit          pause;

		// Directed: extremes, every key class, modifiers and alt selection
		queue_event(16'hFFFF, KEY_A, KV_PRESS);
		queue_event(EV_KEY, KEY_NONE, KV_PRESS);
		queue_event(EV_KEY, KEY_ESCAPE, KV_PRESS);
		queue_event(EV_KEY, KEY_A, KV_REPEAT);
		queue_event(EV_KEY, KEY_ROM_LAST, KV_PRESS);
		queue_event(EV_KEY, KEY_A, KV_RELEASE);
		queue_event(EV_KEY, KEY_LSHIFT, KV_PRESS);
		queue_event(EV_KEY, KEY_DIGIT2, KV_PRESS);
		queue_event(EV_KEY, KEY_Z, KV_PRESS);
		queue_event(EV_KEY, KEY_RSHIFT, KV_RELEASE);
		queue_event(EV_KEY, KEY_LCTRL, KV_PRESS);
		queue_event(EV_KEY, KEY_A, KV_PRESS);
		queue_event(EV_KEY, KEY_Z, KV_REPEAT);
		queue_event(EV_KEY, KEY_RCTRL, KV_RELEASE);
		queue_event(EV_KEY, KEY_SPACE, KV_PRESS);
		queue_event(EV_KEY, KEY_UP, KV_PRESS);
		queue_event(EV_KEY, KEY_DOWN, KV_PRESS);
		queue_event(EV_KEY, KEY_LEFT, KV_PRESS);
		queue_event(EV_KEY, KEY_RIGHT, KV_REPEAT);
		queue_event(EV_KEY, KEY_DELETE, KV_PRESS);
		queue_event(EV_KEY, KEY_TOP, KV_PRESS);
		queue_event(EV_KEY, KEY_LALT, KV_PRESS);
		queue_event(EV_KEY, KEY_DIGIT1, KV_RELEASE);
		queue_event(EV_KEY, KEY_DIGIT4, KV_PRESS);
		queue_event(EV_KEY, KEY_ESCAPE, KV_PRESS);
		queue_event(EV_KEY, KEY_RALT, KV_RELEASE);

		// Random: mostly key events, some modifier changes and foreign events
		keys_made = 0;
		pause = 1'b1;
		while (keys_made < RANDOM_KEYS) begin
			r = $urandom_range(0, 99);
			if (keys_made == RANDOM_KEYS / 2 && r >= 13)
				pause = 1'b1;
			if (r < 8) begin
				queue_event(EV_KEY, MODIFIER_KEYS[$urandom_range(0, 5)],
					$urandom_range(0, 1) ? KV_PRESS : KV_RELEASE, pause);
			end else if (r < 13) begin
				queue_event(16'($urandom_range(0, 65535)), 10'($urandom_range(0, 767)),
					2'($urandom_range(0, 2)), pause);
			end else begin
				if (r < 61)
					code = 10'($urandom_range(0, 53));
				else if (r < 68)
					code = KEY_SPACE;
				else if (r < 81)
					code = CURSOR_KEYS[$urandom_range(0, 4)];
				else if (r < 91)
					code = 10'($urandom_range(0, 11));
				else
					code = 10'($urandom_range(0, 767));
				queue_event(EV_KEY, code, ($urandom_range(0, 3) == 0) ?
					KV_RELEASE : 2'($urandom_range(1, 2)), pause);
				keys_made++;
			end
			pause = 1'b0;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_events.size() > 0)
			@(posedge clk);
		while (chars_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d events taken, %0d results checked (%0d terminal selects)",
			events_taken, results_seen, selects_due);
		$display("%0d cycles with the input held back, %0d mismatches",
			stall_cycles, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
